// File: rtl/sha512_block_compression_macros.svh
// Assertion macros shared by the SHA-512 compression RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SHA512_BLOCK_COMPRESSION_MACROS_SVH
`define SHA512_BLOCK_COMPRESSION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define S512C_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define S512C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/s512c_pkg.sv
// Package for the SHA-512 compression block: sizes, types, command struct,
// round constants and the sigma functions. No dependencies.
package s512c_pkg;

   localparam int unsigned WORD_W           = 64;
   localparam int unsigned CHAIN_WORDS      = 8;
   localparam int unsigned BLOCK_WORD_COUNT = 16;
   localparam int unsigned ROUND_COUNT      = 80;
   localparam int unsigned POS_W            = $clog2(BLOCK_WORD_COUNT);
   // one more than the last round so the lookahead constant index fits
   localparam int unsigned ROUND_IDX_W      = $clog2(ROUND_COUNT + 1);
   localparam int unsigned SEL_W            = $clog2(CHAIN_WORDS);
   localparam int unsigned CSR_DATA_W       = WORD_W;
   localparam int unsigned CSR_ADDR_W       = SEL_W + 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0] chain_type;
   typedef logic [BLOCK_WORD_COUNT-1:0][WORD_W-1:0] sched_type;

   typedef struct packed {
      logic                   word_load;   // input transaction accepted
      logic                   first_word;  // accepted word is a block's first
      logic                   prep;        // load working vars, prime schedule
      logic                   round;       // one compression round
      logic                   final_add;   // fold into chaining value, load output
      logic [ROUND_IDX_W-1:0] const_idx;   // constant for the following round
   } dp_cmd_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      logic [2*WORD_W-1:0] both;
      both = {x, x} >> n;
      return both[WORD_W-1:0];
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   // Round constants; indexes past the last round read as zero.
   function automatic word_type round_const(input logic [ROUND_IDX_W-1:0] idx);
      word_type k;
      unique case (idx)
         7'd0:  k = 64'h428a2f98d728ae22;
         7'd1:  k = 64'h7137449123ef65cd;
         7'd2:  k = 64'hb5c0fbcfec4d3b2f;
         7'd3:  k = 64'he9b5dba58189dbbc;
         7'd4:  k = 64'h3956c25bf348b538;
         7'd5:  k = 64'h59f111f1b605d019;
         7'd6:  k = 64'h923f82a4af194f9b;
         7'd7:  k = 64'hab1c5ed5da6d8118;
         7'd8:  k = 64'hd807aa98a3030242;
         7'd9:  k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c;
         7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f;
         7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235;
         7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2;
         7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5;
         7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275;
         7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4;
         7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab;
         7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f;
         7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2;
         7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f;
         7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc;
         7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed;
         7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de;
         7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6;
         7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364;
         7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791;
         7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218;
         7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a;
         7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8;
         7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99;
         7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63;
         7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373;
         7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc;
         7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72;
         7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28;
         7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915;
         7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c;
         7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e;
         7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba;
         7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae;
         7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84;
         7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc;
         7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6;
         7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec;
         7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/s512c_req_if.sv
// Input channel: one 64-bit block word per transaction plus new-message flag.
// Depends on s512c_pkg.
interface s512c_req_if;
   logic                valid;
   logic                ready;
   s512c_pkg::word_type message_word;
   logic                new_message;

   modport source (output valid, output message_word, output new_message, input ready);
   modport sink   (input valid, input message_word, input new_message, output ready);
endinterface

// File: rtl/s512c_rsp_if.sv
// Result channel: the eight updated chaining value words per transaction.
// Depends on s512c_pkg.
interface s512c_rsp_if;
   logic                valid;
   logic                ready;
   s512c_pkg::word_type digest0;
   s512c_pkg::word_type digest1;
   s512c_pkg::word_type digest2;
   s512c_pkg::word_type digest3;
   s512c_pkg::word_type digest4;
   s512c_pkg::word_type digest5;
   s512c_pkg::word_type digest6;
   s512c_pkg::word_type digest7;

   modport source (output valid, input ready, output digest0, output digest1,
                   output digest2, output digest3, output digest4, output digest5,
                   output digest6, output digest7);
   modport sink   (input valid, output ready, input digest0, input digest1,
                   input digest2, input digest3, input digest4, input digest5,
                   input digest6, input digest7);
endinterface

// File: rtl/s512c_csr.sv
// APB-style register file holding the eight initial chaining value words.
// Depends on s512c_pkg.
module s512c_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [s512c_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [s512c_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [s512c_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready,
   output s512c_pkg::chain_type                 init_words
);
   import s512c_pkg::*;

   chain_type        init_ff;
   chain_type        init_in;
   logic [SEL_W-1:0] sel;
   logic             wr_en;

   // registers sit on 8-byte boundaries
   assign sel        = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = init_ff[sel];
   assign init_words = init_ff;

   always_comb begin
      init_in = init_ff;
      if (wr_en) begin
         init_in[sel] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else begin
         init_ff <= init_in;
      end
   end

endmodule

// File: rtl/s512c_ctrl.sv
// Controller: word counter, round counter and sequencing of the datapath.
// Depends on s512c_pkg and the assertion macro header.
`include "sha512_block_compression_macros.svh"

module s512c_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output s512c_pkg::dp_cmd_type cmd
);
   import s512c_pkg::*;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PREP,
      ST_ROUND,
      ST_FINAL
   } state_type;

   localparam logic [POS_W-1:0]       POS_LAST   = POS_W'(BLOCK_WORD_COUNT - 1);
   localparam logic [ROUND_IDX_W-1:0] ROUND_LAST = ROUND_IDX_W'(ROUND_COUNT - 1);

   state_type              state_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [ROUND_IDX_W-1:0] round_ff;
   logic                   rsp_valid_ff;
   logic                   accept;
   logic                   final_go;

   always_comb begin
      req_ready = (state_ff == ST_LOAD);
      accept    = req_valid & req_ready;
      // the output register can take a new result once the old one leaves
      final_go  = (state_ff == ST_FINAL) & (~rsp_valid_ff | rsp_ready);

      cmd            = '0;
      cmd.word_load  = accept;
      cmd.first_word = (pos_ff == '0);
      cmd.prep       = (state_ff == ST_PREP);
      cmd.round      = (state_ff == ST_ROUND);
      cmd.final_add  = final_go;
      cmd.const_idx  = (state_ff == ST_ROUND) ? round_ff + 1'b1 : '0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pos_ff       <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (pos_ff == POS_LAST) begin
                     pos_ff   <= '0;
                     state_ff <= ST_PREP;
                  end else begin
                     pos_ff <= pos_ff + 1'b1;
                  end
               end
            end
            ST_PREP: begin
               round_ff <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (round_ff == ROUND_LAST) begin
                  state_ff <= ST_FINAL;
               end else begin
                  round_ff <= round_ff + 1'b1;
               end
            end
            ST_FINAL: begin
               if (final_go) begin
                  state_ff <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase

         if (final_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `S512C_ASSERT_NEXT(a_block_end_starts_prep, clock, reset, accept && pos_ff == POS_LAST, state_ff == ST_PREP && pos_ff == '0, "sixteenth word did not start compression")
   `S512C_ASSERT_NEXT(a_round_advance, clock, reset, state_ff == ST_ROUND && round_ff != ROUND_LAST, state_ff == ST_ROUND && round_ff == $past(round_ff) + 1'b1, "round counter skipped")
   `S512C_ASSERT_NEXT(a_last_round_final, clock, reset, state_ff == ST_ROUND && round_ff == ROUND_LAST, state_ff == ST_FINAL, "last round not followed by final add")
   `S512C_ASSERT_NEXT(a_final_shows_result, clock, reset, final_go, rsp_valid_ff && state_ff == ST_LOAD, "final add did not present a result")

endmodule

// File: rtl/s512c_datapath.sv
// Datapath: schedule window, working variables, chaining value, output register.
// Depends on s512c_pkg.
module s512c_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  s512c_pkg::dp_cmd_type cmd,
   input  s512c_pkg::word_type   message_word,
   input  logic                  new_message,
   input  s512c_pkg::chain_type  init_words,
   output s512c_pkg::chain_type  digest
);
   import s512c_pkg::*;

   sched_type window_ff;   // W[j-16] .. W[j-1], oldest at index 0
   sched_type window_in;
   chain_type work_ff;     // a at index 0 .. h at index 7
   chain_type work_in;
   chain_type chain_ff;
   chain_type chain_in;
   chain_type chain_sum;
   chain_type digest_ff;
   word_type  hkw_ff;      // h + K[t] + W[t] for the coming round
   word_type  hkw_in;
   word_type  sched_new;
   word_type  h_src;
   word_type  t1;
   word_type  t2;
   word_type  choose;
   word_type  major;

   always_comb begin
      sched_new = small_sigma1(window_ff[14]) + window_ff[9] +
                  small_sigma0(window_ff[1]) + window_ff[0];

      window_in = window_ff;
      if (cmd.word_load) begin
         window_in = {message_word, window_ff[BLOCK_WORD_COUNT-1:1]};
      end else if (cmd.prep | cmd.round) begin
         window_in = {sched_new, window_ff[BLOCK_WORD_COUNT-1:1]};
      end

      // next round's h is chain h at prep, else current g
      h_src  = cmd.prep ? chain_ff[7] : work_ff[6];
      hkw_in = h_src + round_const(cmd.const_idx) + window_ff[0];

      choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
               (work_ff[1] & work_ff[2]);
      t1     = hkw_ff + big_sigma1(work_ff[4]) + choose;
      t2     = big_sigma0(work_ff[0]) + major;

      work_in = work_ff;
      if (cmd.prep) begin
         work_in = chain_ff;
      end else if (cmd.round) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end

      for (int i = 0; i < CHAIN_WORDS; i++) begin
         chain_sum[i] = chain_ff[i] + work_ff[i];
      end

      chain_in = chain_ff;
      if (cmd.word_load & cmd.first_word & new_message) begin
         chain_in = init_words;
      end else if (cmd.final_add) begin
         chain_in = chain_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      work_ff   <= work_in;
      if (cmd.prep | cmd.round) begin
         hkw_ff <= hkw_in;
      end
      if (cmd.final_add) begin
         digest_ff <= chain_sum;
      end
   end

   assign digest = digest_ff;

endmodule

// File: rtl/sha512_block_compression.sv
// SHA-512 block compression, top level.
// Channels: req_chan takes one 64-bit big-endian block word per transaction;
// new_message on a block's first word reloads the chaining value from the
// eight init registers (ignored on other words). rsp_chan returns the eight
// updated chaining value words once per sixteen input words.
// The csr_ port writes/reads init_word0..7 at byte address 8*i, 64-bit data.
// Timing: all sixteen words of a block are taken one per cycle while req_chan.valid
// is held high. After the 16th word the single round unit does a setup step, 80
// rounds and a final add. The 80-round loop through the one round unit sets the
// pace of a block; req_chan.ready stays low while it runs.
// A finished result sits in an output register, so the next block's words are
// taken while the receiver stalls; the final add of that next block waits
// until the older result has been taken.
// Reset (synchronous, active high) clears the init registers, the chaining
// value and the word count, and drops rsp_chan.valid.
// Depends on s512c_pkg, the channel interfaces, s512c_csr, s512c_ctrl,
// s512c_datapath.
module sha512_block_compression (
   input  logic                              clock,
   input  logic                              reset,
   s512c_req_if.sink                         req_chan,
   s512c_rsp_if.source                       rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [s512c_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [s512c_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [s512c_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import s512c_pkg::*;

   chain_type  init_words;
   chain_type  digest;
   dp_cmd_type cmd;
   logic       req_ready;
   logic       rsp_valid;

   s512c_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .init_words  (init_words)
   );

   s512c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   s512c_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .message_word (req_chan.message_word),
      .new_message  (req_chan.new_message),
      .init_words   (init_words),
      .digest       (digest)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.digest0 = digest[0];
   assign rsp_chan.digest1 = digest[1];
   assign rsp_chan.digest2 = digest[2];
   assign rsp_chan.digest3 = digest[3];
   assign rsp_chan.digest4 = digest[4];
   assign rsp_chan.digest5 = digest[5];
   assign rsp_chan.digest6 = digest[6];
   assign rsp_chan.digest7 = digest[7];

endmodule

// File: sim/sha512_block_compression_test.sv
`timescale 1ns / 100ps
// Self-checking bench for sha512_block_compression: streams block words with
// random gaps and back-pressure, predicts every digest, reprograms the IV regs.
// Depends on s512c_pkg, s512c_req_if, s512c_rsp_if and the block's RTL.
module sha512_block_compression_test;

   import s512c_pkg::*;

   typedef logic [7:0][63:0] digest_words_type;

   typedef struct packed {
      logic [63:0] msg_word;
      logic        restart;
   } block_word_type;

   localparam int NUM_SETTINGS    = 7;
   localparam int HOLD_OFF_AT     = 6;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int SETTLE_CYCLES   = 100;

   localparam logic [63:0] SHA512_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam logic [63:0] STANDARD_IV [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   // opening block: field extremes, flag set again mid-block, flag on the last word
   localparam logic [63:0] DIRECTED_WORDS [16] = '{
      64'h0000000000000000, 64'hffffffffffffffff, 64'h0000000000000001, 64'h8000000000000000,
      64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'h0123456789abcdef, 64'hfedcba9876543210,
      64'hffffffffffffffff, 64'hffffffffffffffff, 64'h0000000000000000, 64'h7fffffffffffffff,
      64'hfffffffffffffffe, 64'h00000000ffffffff, 64'hffffffff00000000, 64'hffffffffffffffff
   };
   localparam logic [15:0] DIRECTED_FLAGS = 16'b1000_0000_0010_1001;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   s512c_req_if req_bus ();
   s512c_rsp_if rsp_bus ();

   sha512_block_compression u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [63:0]      init_shadow [8];
   logic [63:0]      chain_model [8];
   logic [63:0]      block_words [16];
   logic [3:0]       next_word_idx;
   digest_words_type digest_queue [$];

   block_word_type   pending_words [$];
   block_word_type   cur_item;
   int               burst_left;
   int               gap_left;
   logic [15:0]      stall_pattern;
   int               pattern_step;
   int               hold_off_left;
   logic             hold_off_done;

   int mismatch_count   = 0;
   int words_accepted   = 0;
   int digests_seen     = 0;
   int restarts_honored = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] sum0(input logic [63:0] x);
      return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
   endfunction

   function automatic logic [63:0] sum1(input logic [63:0] x);
      return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
   endfunction

   function automatic logic [63:0] mix0(input logic [63:0] x);
      return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] mix1(input logic [63:0] x);
      return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
   endfunction

   function automatic void compress_block_words();
      logic [63:0] w [80];
      logic [63:0] v [8];
      logic [63:0] t1, t2;
      for (int t = 0; t < 80; t++) begin
         if (t < 16)
            w[t] = block_words[t];
         else
            w[t] = mix1(w[t-2]) + w[t-7] + mix0(w[t-15]) + w[t-16];
      end
      v = chain_model;
      for (int t = 0; t < 80; t++) begin
         t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA512_K[t] + w[t];
         t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain_model[i] = chain_model[i] + v[i];
   endfunction

   // one accepted word; queues a digest when it closes a block
   function automatic void absorb_word(input block_word_type item);
      digest_words_type d;
      if (next_word_idx == 0 && item.restart) begin
         chain_model = init_shadow;
         restarts_honored++;
      end
      block_words[next_word_idx] = item.msg_word;
      if (next_word_idx == 4'd15) begin
         compress_block_words();
         for (int i = 0; i < 8; i++)
            d[i] = chain_model[i];
         digest_queue.push_back(d);
      end
      next_word_idx = next_word_idx + 4'd1;
   endfunction

   function automatic logic [63:0] random_word();
      int k;
      k = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << k;
         3: return ~(64'd1 << k);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] init_setting(input int setting, input int idx);
      case (setting)
         1: return '1;
         2: return STANDARD_IV[idx];
         4: return idx[0] ? 64'haaaaaaaaaaaaaaaa : 64'h5555555555555555;
         5: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   task automatic csr_access(input logic is_write, input int idx, input logic [63:0] wdata,
                             output logic [63:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_bus.valid || digest_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // input driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.message_word <= '0;
         req_bus.new_message  <= 1'b0;
         burst_left           <= 1;
         gap_left             <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_word(cur_item);
            words_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left      <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               cur_item = pending_words.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.message_word <= cur_item.msg_word;
               req_bus.new_message  <= cur_item.restart;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 30);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off so the block fills up and blocks its input
   always @(posedge clock) begin
      if (reset) begin
         hold_off_left <= 0;
         hold_off_done <= 1'b0;
      end else if (!hold_off_done && digests_seen == HOLD_OFF_AT) begin
         hold_off_left <= HOLD_OFF_CYCLES;
         hold_off_done <= 1'b1;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
      end
   end

   // receiver stall pattern, reshuffled each time pattern_step wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_pattern <= '0;
         pattern_step  <= 0;
      end else begin
         rsp_bus.ready <= (hold_off_left == 0) && !stall_pattern[pattern_step];
         if (pattern_step == 15) begin
            pattern_step <= 0;
            case ($urandom_range(0, 3))
               0: stall_pattern <= '0;
               1: stall_pattern <= 16'($urandom) & 16'($urandom);
               default: stall_pattern <= 16'($urandom);
            endcase
         end else begin
            pattern_step <= pattern_step + 1;
         end
      end
   end

   // digest monitor
   always @(posedge clock) begin
      digest_words_type got;
      digest_words_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.digest7, rsp_bus.digest6, rsp_bus.digest5, rsp_bus.digest4,
                rsp_bus.digest3, rsp_bus.digest2, rsp_bus.digest1, rsp_bus.digest0};
         if (digest_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("digest transaction with none pending: digest0 %h", got[0]);
         end else begin
            want = digest_queue.pop_front();
            for (int i = 0; i < 8; i++)
               if (got[i] !== want[i])
                  report_mismatch($sformatf("digest%0d of digest #%0d", i, digests_seen),
                                  want[i], got[i]);
         end
         digests_seen <= digests_seen + 1;
      end
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      block_word_type item;
      logic [63:0]    readback;
      int             gen_pos;
      int             phase_words;

      req_bus.valid        = 1'b0;
      req_bus.message_word = '0;
      req_bus.new_message  = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      for (int i = 0; i < 8; i++) begin
         init_shadow[i] = '0;
         chain_model[i] = '0;
      end
      next_word_idx = '0;
      gen_pos       = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
         if (setting != 0) begin
            wait_drained();
            for (int i = 0; i < 8; i++) begin
               init_shadow[i] = init_setting(setting, i);
               csr_access(1'b1, i, init_shadow[i], readback);
            end
         end
         // the first pass checks the reset values
         for (int i = 0; i < 8; i++) begin
            csr_access(1'b0, i, '0, readback);
            if (readback !== init_shadow[i])
               report_mismatch($sformatf("init_word%0d readback", i), init_shadow[i], readback);
         end
         @(negedge clock);

         if (setting == 0) begin
            for (int i = 0; i < 16; i++) begin
               item.msg_word = DIRECTED_WORDS[i];
               item.restart  = DIRECTED_FLAGS[i];
               pending_words.push_back(item);
            end
         end
         // two settings split a block across a register update
         phase_words = (setting == 0) ? 320 : (setting == 3) ? 231 : (setting == 4) ? 233 : 224;
         for (int n = 0; n < phase_words; n++) begin
            item.msg_word = random_word();
            if (gen_pos == 0)
               item.restart = ($urandom_range(0, 2) == 0);
            else
               item.restart = ($urandom_range(0, 9) == 0);
            pending_words.push_back(item);
            gen_pos = (gen_pos + 1) % 16;
         end
      end
      wait_drained();

      $display("Streamed %0d block words, checked %0d digests, %0d message restarts.",
               words_accepted, digests_seen, restarts_honored);
      $display("Covered %0d init-value settings, incl. all-zero, all-one and standard IV.",
               NUM_SETTINGS);
      if (mismatch_count == 0 && digest_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
